@@ rtl/top_k_score_selector_macros.svh @@
// Assertion macros for the top-k score selector.
// Included by the top level; no other dependencies.
`ifndef TOP_K_SCORE_SELECTOR_MACROS_SVH
`define TOP_K_SCORE_SELECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tks assertion failed");
// next-cycle implication
`define TKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tks assertion failed");
`else
`define TKS_ASSERT_NOW(label, clk, rst, ante, cons)
`define TKS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tks_pkg.sv @@
// Package for the top-k score selector: constants, types, score helpers.
// No dependencies.
`timescale 1ns / 1ps
package tks_pkg;

   localparam int MAX_K_DEF = 64;
   localparam int MAX_N_DEF = 4096;
   localparam int SCORE_W   = 32;
   localparam int K_W       = 7;
   localparam int OUT_IDX_W = 12;
   localparam logic [K_W-1:0] K_RESET = 7'd64;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DECIDE,
      BK_ESCAN,
      BK_EMIT
   } back_state_type;

   // status of the back end, seen by the top level
   typedef struct packed {
      logic busy;
      logic emitting;
   } back_status_type;

   // +0 and -0 fold together
   function automatic logic [SCORE_W-1:0] fold_zero(input logic [SCORE_W-1:0] b);
      logic [SCORE_W-1:0] r;
      r = (b[30:0] == 31'd0) ? '0 : b;
      return r;
   endfunction

   // monotone unsigned key: larger key means larger score
   function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] b);
      logic [SCORE_W-1:0] r;
      r = b[31] ? ~b : (b | 32'h8000_0000);
      return r;
   endfunction

   // NaN or negative infinity is never scored
   function automatic logic is_skipped(input logic [SCORE_W-1:0] b);
      logic nan;
      nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      return nan || (b == 32'hFF80_0000);
   endfunction

endpackage

@@ rtl/tks_if.sv @@
// Handshake interfaces for the score word and result word channels.
// No dependencies.
`timescale 1ns / 1ps
interface tks_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] score_bits;
   logic        last_item;
   modport source (output valid, score_bits, last_item, input ready);
   modport sink   (input valid, score_bits, last_item, output ready);
endinterface

interface tks_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] selected_index;
   logic [6:0]  selected_total;
   logic        final_result;
   logic        none_selected;
   logic        stream_overflow;
   modport source (output valid, selected_index, selected_total, final_result,
                   none_selected, stream_overflow, input ready);
   modport sink   (input valid, selected_index, selected_total, final_result,
                   none_selected, stream_overflow, output ready);
endinterface

@@ rtl/top_k_score_selector.sv @@
// Streaming top-k score selector. A scored word runs a scan in the back end (one slot
// memory read per cycle to find a free or worst slot); skipped words need no scan.
// At the last word each result word is found by an index-order scan over the slot
// memory; an empty result needs no scan. Two-entry queue.
// Synchronous active-high reset clears the slot valid bits, counters and k to 64.
`timescale 1ns / 1ps
`include "top_k_score_selector_macros.svh"
module top_k_score_selector import tks_pkg::*; #(
   parameter int MAX_K = MAX_K_DEF,
   parameter int MAX_N = MAX_N_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_en,
   input  logic [K_W-1:0] csr_write_data,
   tks_req_if.sink        req_if,
   tks_rsp_if.source      rsp_if
);
   localparam int IDX_W = $clog2(MAX_N);
   localparam int Q_W   = SCORE_W + IDX_W + 3;

   logic           push_valid, push_ready, pop_valid, pop_ready;
   logic [Q_W-1:0] push_data, pop_data;
   back_status_type back_status;

   tks_front #(.MAX_N(MAX_N), .IDX_W(IDX_W)) u_front (
      .clock, .reset, .req_if,
      .push_valid, .push_ready, .push_data
   );

   tks_fifo #(.WIDTH(Q_W), .DEPTH(2)) u_fifo (
      .clock, .reset,
      .push_valid, .push_ready, .push_data,
      .pop_valid, .pop_ready, .pop_data
   );

   tks_back #(.MAX_K(MAX_K), .IDX_W(IDX_W)) u_back (
      .clock, .reset, .csr_write_en, .csr_write_data,
      .pop_valid, .pop_ready, .pop_data,
      .rsp_if, .status(back_status)
   );

   // checks
   `TKS_ASSERT_NOW(a_none_is_final, clock, reset, rsp_if.valid && rsp_if.none_selected, rsp_if.final_result && rsp_if.selected_total == 7'd0)
   `TKS_ASSERT_NOW(a_pop_only_idle, clock, reset, pop_valid && pop_ready, !back_status.busy)
   `TKS_ASSERT_NOW(a_emit_busy, clock, reset, back_status.emitting, back_status.busy)
   `TKS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_if.valid && !back_status.busy)
endmodule

@@ rtl/tks_front.sv @@
// Front end: accepts score words, counts positions, classifies each word.
// Depends on tks_pkg and tks_if.
`timescale 1ns / 1ps
module tks_front import tks_pkg::*; #(
   parameter int MAX_N = MAX_N_DEF,
   parameter int IDX_W = $clog2(MAX_N)
) (
   input  logic                     clock,
   input  logic                     reset,
   tks_req_if.sink                  req_if,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [SCORE_W+IDX_W+2:0] push_data
);
   localparam int POS_W = $clog2(MAX_N + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ovf_ff, ovf_in;
   logic             accept, in_range, scoreable;
   logic [SCORE_W-1:0] bits;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid && push_ready;

   // classify the word
   assign in_range  = pos_ff < POS_W'(MAX_N);
   assign bits      = fold_zero(req_if.score_bits);
   assign scoreable = in_range && !is_skipped(bits);
   assign push_data = {order_key(bits), pos_ff[IDX_W-1:0], scoreable,
                       req_if.last_item, ovf_ff || !in_range};

   // position counter saturates; last word starts a new stream
   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_if.last_item) begin
            pos_in = '0;
            ovf_in = 1'b0;
         end else if (in_range) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end
endmodule

@@ rtl/tks_fifo.sv @@
// Small queue between the front and back ends.
// Depends on tks_pkg.
`timescale 1ns / 1ps
module tks_fifo import tks_pkg::*; #(
   parameter int WIDTH = SCORE_W,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end
endmodule

@@ rtl/tks_back.sv @@
// Back end: slot store, worst-entry and next-index scans, result register.
// Depends on tks_pkg and tks_if.
`timescale 1ns / 1ps
module tks_back import tks_pkg::*; #(
   parameter int MAX_K = MAX_K_DEF,
   parameter int IDX_W = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [K_W-1:0]           csr_write_data,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  logic [SCORE_W+IDX_W+2:0] pop_data,
   tks_rsp_if.source                rsp_if,
   output back_status_type          status
);
   localparam int SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CNT_W  = $clog2(MAX_K + 1);
   localparam int MEM_W  = SCORE_W + IDX_W;

   back_state_type state_ff, state_in;

   // slot store: key and index in memory, valid bits in flops
   logic [MEM_W-1:0]  mem [MAX_K];
   logic [MEM_W-1:0]  rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [MAX_K-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [K_W-1:0]    k_ff;
   logic [K_W-1:0]    limit;

   // current command
   logic [SCORE_W-1:0] ckey_ff;
   logic [IDX_W-1:0]   cidx_ff;
   logic               clast_ff, covf_ff;

   // scan control and candidate
   logic [SLOT_W:0]    issue_ff, issue_in;
   logic               proc_ff, proc_in;
   logic [SLOT_W-1:0]  pslot_ff;
   logic               scan_done;
   logic               free_found_ff, free_found_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;
   logic               cand_ff, cand_in;
   logic [SLOT_W-1:0]  cand_slot_ff, cand_slot_in;
   logic [SCORE_W-1:0] cand_key_ff, cand_key_in;
   logic [IDX_W-1:0]   cand_idx_ff, cand_idx_in;
   logic               first_ff, first_in;
   logic [IDX_W-1:0]   prev_idx_ff, prev_idx_in;
   logic [CNT_W-1:0]   emitted_ff, emitted_in;

   // result register
   logic                 rv_ff, rv_in;
   logic [OUT_IDX_W-1:0] r_index_ff, r_index_in;
   logic [K_W-1:0]       r_total_ff, r_total_in;
   logic                 r_final_ff, r_final_in, r_none_ff, r_none_in, r_ovf_ff, r_ovf_in;

   logic [SCORE_W-1:0] pkey;
   logic [IDX_W-1:0]   pidx;
   logic               pvalid, take, out_free, is_final, replace;

   assign limit     = (k_ff > K_W'(MAX_K)) ? K_W'(MAX_K) : k_ff;
   assign pkey      = rd_data_ff[MEM_W-1:IDX_W];
   assign pidx      = rd_data_ff[IDX_W-1:0];
   assign pvalid    = valid_ff[pslot_ff];
   assign scan_done = proc_ff && (pslot_ff == SLOT_W'(MAX_K - 1));
   assign out_free  = !rv_ff || rsp_if.ready;
   assign take      = pop_valid && pop_ready;
   assign is_final  = (count_ff == '0) || (emitted_ff + 1'b1 == count_ff);
   assign replace   = cand_ff && ((cand_key_ff < ckey_ff) ||
                      ((cand_key_ff == ckey_ff) && (cand_idx_ff > cidx_ff)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (pop_data[2]) state_in = BK_SCAN;
               else if (pop_data[1]) state_in = (count_ff == '0) ? BK_EMIT : BK_ESCAN;
            end
         end
         BK_SCAN:   if (scan_done) state_in = BK_DECIDE;
         BK_DECIDE: begin
            if (clast_ff) state_in = (count_in == '0) ? BK_EMIT : BK_ESCAN;
            else state_in = BK_IDLE;
         end
         BK_ESCAN:  if (scan_done) state_in = BK_EMIT;
         BK_EMIT:   if (out_free) state_in = is_final ? BK_IDLE : BK_ESCAN;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      pop_ready       = (state_ff == BK_IDLE);
      status.busy     = (state_ff != BK_IDLE);
      status.emitting = (state_ff == BK_ESCAN) || (state_ff == BK_EMIT);
   end

   // datapath next values
   always_comb begin
      issue_in      = issue_ff;
      proc_in       = 1'b0;
      rd_addr       = issue_ff[SLOT_W-1:0];
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      cand_in       = cand_ff;
      cand_slot_in  = cand_slot_ff;
      cand_key_in   = cand_key_ff;
      cand_idx_in   = cand_idx_ff;
      first_in      = first_ff;
      prev_idx_in   = prev_idx_ff;
      emitted_in    = emitted_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = free_slot_ff;
      rv_in         = rv_ff && !rsp_if.ready;
      r_index_in    = r_index_ff;
      r_total_in    = r_total_ff;
      r_final_in    = r_final_ff;
      r_none_in     = r_none_ff;
      r_ovf_in      = r_ovf_ff;

      // issue reads while scanning
      if ((state_ff == BK_SCAN || state_ff == BK_ESCAN) && issue_ff < (SLOT_W+1)'(MAX_K)) begin
         issue_in = issue_ff + 1'b1;
         proc_in  = 1'b1;
      end

      // fold in one slot per cycle
      if (proc_ff && state_ff == BK_SCAN) begin
         if (!pvalid) begin
            if (!free_found_ff && (K_W'(pslot_ff) < limit)) begin
               free_found_in = 1'b1;
               free_slot_in  = pslot_ff;
            end
         end else if (!cand_ff || (pkey < cand_key_ff) ||
                      ((pkey == cand_key_ff) && (pidx > cand_idx_ff))) begin
            cand_in      = 1'b1;
            cand_slot_in = pslot_ff;
            cand_key_in  = pkey;
            cand_idx_in  = pidx;
         end
      end
      if (proc_ff && state_ff == BK_ESCAN && pvalid && (first_ff || pidx > prev_idx_ff) &&
          (!cand_ff || pidx < cand_idx_ff)) begin
         cand_in     = 1'b1;
         cand_idx_in = pidx;
      end

      // new command: restart the scan
      if (state_ff == BK_IDLE && take) begin
         issue_in      = '0;
         free_found_in = 1'b0;
         cand_in       = 1'b0;
         first_in      = 1'b1;
         emitted_in    = '0;
      end

      // place the score
      if (state_ff == BK_DECIDE) begin
         if (free_found_ff) begin
            wr_en                  = 1'b1;
            valid_in[free_slot_ff] = 1'b1;
            count_in               = count_ff + 1'b1;
         end else if (replace) begin
            wr_en   = 1'b1;
            wr_addr = cand_slot_ff;
         end
         issue_in = '0;
         cand_in  = 1'b0;
      end

      // load one result word; an empty selection reports index zero
      if (state_ff == BK_EMIT && out_free) begin
         rv_in       = 1'b1;
         r_index_in  = (count_ff == '0) ? '0 : OUT_IDX_W'(cand_idx_ff);
         r_total_in  = K_W'(count_ff);
         r_final_in  = is_final;
         r_none_in   = (count_ff == '0);
         r_ovf_in    = covf_ff;
         prev_idx_in = cand_idx_ff;
         first_in    = 1'b0;
         emitted_in  = emitted_ff + 1'b1;
         issue_in    = '0;
         cand_in     = 1'b0;
         if (is_final) begin
            valid_in = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         k_ff          <= K_RESET;
         valid_ff      <= '0;
         count_ff      <= '0;
         issue_ff      <= '0;
         proc_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         cand_ff       <= 1'b0;
         first_ff      <= 1'b1;
         emitted_ff    <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_en) k_ff <= csr_write_data;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         proc_ff       <= proc_in;
         free_found_ff <= free_found_in;
         cand_ff       <= cand_in;
         first_ff      <= first_in;
         emitted_ff    <= emitted_in;
         rv_ff         <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pslot_ff     <= rd_addr;
      free_slot_ff <= free_slot_in;
      cand_slot_ff <= cand_slot_in;
      cand_key_ff  <= cand_key_in;
      cand_idx_ff  <= cand_idx_in;
      prev_idx_ff  <= prev_idx_in;
      r_index_ff   <= r_index_in;
      r_total_ff   <= r_total_in;
      r_final_ff   <= r_final_in;
      r_none_ff    <= r_none_in;
      r_ovf_ff     <= r_ovf_in;
      if (take) begin
         ckey_ff  <= pop_data[SCORE_W+IDX_W+2:IDX_W+3];
         cidx_ff  <= pop_data[IDX_W+2:3];
         clast_ff <= pop_data[1];
         covf_ff  <= pop_data[0];
      end
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {ckey_ff, cidx_ff};
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_if.valid           = rv_ff;
   assign rsp_if.selected_index  = r_index_ff;
   assign rsp_if.selected_total  = r_total_ff;
   assign rsp_if.final_result    = r_final_ff;
   assign rsp_if.none_selected   = r_none_ff;
   assign rsp_if.stream_overflow = r_ovf_ff;
endmodule
